@@ rtl/btls_pkg.sv @@
// Shared types, codes and defaults of the BMP texture loader and sampler.
package btls_pkg;

    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT_DEF   = 256;
    localparam int UV_FRAC_BITS_DEF = 16;
    localparam int HEADER_BYTES     = 54;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SIGNATURE  = 3'd1,
        ST_DEPTH      = 3'd2,
        ST_SIZE       = 3'd3,
        ST_OFFSET     = 3'd4,
        ST_NO_TEXTURE = 3'd5
    } t_status;

    // Request passed from the front end to the back end
    typedef struct packed {
        logic        op;
        logic [7:0]  file_byte;
        logic        first_byte;
        logic [31:0] u_coord;
        logic [31:0] v_coord;
    } t_req;

    // Result passed to the output register
    typedef struct packed {
        logic       is_sample;
        t_status    status;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_res;

endpackage

@@ rtl/btls_front.sv @@
// Front end: accepts requests into a short queue towards the back end.
module btls_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  btls_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output btls_pkg::t_req o_req
);

    localparam int D = btls_pkg::QUEUE_DEPTH;

    btls_pkg::t_req r_q [D];
    logic [$clog2(D)-1:0] r_wp, r_rp;
    logic [$clog2(D):0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != ($clog2(D)+1)'(D));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_req;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ($clog2(D))'((r_wp + 1'b1) % D);
            if (pop)  r_rp <= ($clog2(D))'((r_rp + 1'b1) % D);
            r_cnt <= r_cnt + ($clog2(D)+1)'(push) - ($clog2(D)+1)'(pop);
        end
    end

endmodule

@@ rtl/btls_back.sv @@
// Back end: BMP parser, texel store and nearest-neighbour sampler.
module btls_back #(
    parameter int MAX_WIDTH    = btls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = btls_pkg::MAX_HEIGHT_DEF,
    parameter int UV_FRAC_BITS = btls_pkg::UV_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  btls_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output btls_pkg::t_res o_res
);

    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FB    = UV_FRAC_BITS;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_PAD    = 5'b10000
    } t_phase;

    typedef enum logic [4:0] {
        SS_IDLE = 5'b00001,
        SS_MUL  = 5'b00010,
        SS_ADDR = 5'b00100,
        SS_READ = 5'b01000,
        SS_DATA = 5'b10000
    } t_sstate;

    t_phase  r_phase;
    t_sstate r_ss;
    logic [31:0] r_pos, r_offset, r_width, r_height;
    logic [15:0] r_depth;
    logic [WB-1:0] r_col;
    logic [HB-1:0] r_row;
    logic [1:0]  r_chan, r_pad;
    logic [15:0] r_part;
    logic        r_bad_b, r_tex_valid;
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rd;

    // row base for texel writes, updated when a row starts
    logic [AB+1:0] r_wbase;
    logic [FB+WB-1:0] r_pu;
    logic [FB+HB-1:0] r_pv;
    logic [AB-1:0] r_raddr;
    logic [WB-1:0] r_px;
    logic [HB-1:0] r_py;

    logic r_ovalid;
    btls_pkg::t_res r_res;

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    logic out_free, fire, is_file, is_samp;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = out_free && (r_ss == SS_IDLE);
    assign fire     = i_valid && o_ready;
    assign is_file  = fire && !i_req.op;
    assign is_samp  = fire && i_req.op;

    logic [WB-1:0] w_t;
    logic [HB-1:0] h_t;
    assign w_t = r_width[WB-1:0];
    assign h_t = r_height[HB-1:0];

    // parser next state
    t_phase n_phase;
    logic [31:0] n_pos, n_offset, n_width, n_height;
    logic [15:0] n_depth, n_part;
    logic [WB-1:0] n_col;
    logic [HB-1:0] n_row;
    logic [1:0] n_chan, n_pad;
    logic n_bad_b, n_tex_valid, n_emit, n_we;
    btls_pkg::t_status n_st;
    logic [7:0] b;
    logic [AB+1:0] n_wbase;
    logic [AB+1:0] waddr;
    logic do_next_row;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_offset = r_offset;
        n_width = r_width; n_height = r_height; n_depth = r_depth;
        n_part = r_part; n_col = r_col; n_row = r_row; n_chan = r_chan;
        n_pad = r_pad; n_bad_b = r_bad_b; n_tex_valid = r_tex_valid;
        n_wbase = r_wbase;
        n_emit = 1'b0; n_we = 1'b0; n_st = btls_pkg::ST_OK;
        do_next_row = 1'b0;
        b = i_req.file_byte;
        waddr = r_wbase + (AB+2)'(r_col);
        if (i_req.first_byte) begin
            n_tex_valid = 1'b0; n_phase = PH_HEADER; n_pos = '0;
            n_offset = '0; n_width = '0; n_height = '0; n_depth = '0;
            n_col = '0; n_row = '0; n_chan = '0; n_pad = '0; n_part = '0;
            n_bad_b = 1'b0;
        end
        unique case (n_phase)
            PH_HEADER: begin
                if (n_pos == 32'd0 && b != btls_pkg::SIG_B) n_bad_b = 1'b1;
                if (n_pos == 32'd1 && (n_bad_b || b != btls_pkg::SIG_M)) begin
                    n_emit = 1'b1; n_st = btls_pkg::ST_SIGNATURE;
                    n_phase = PH_IDLE;
                end else begin
                    case (n_pos[5:0])
                        6'd10: n_offset[7:0]   = b;
                        6'd11: n_offset[15:8]  = b;
                        6'd12: n_offset[23:16] = b;
                        6'd13: n_offset[31:24] = b;
                        6'd18: n_width[7:0]    = b;
                        6'd19: n_width[15:8]   = b;
                        6'd20: n_width[23:16]  = b;
                        6'd21: n_width[31:24]  = b;
                        6'd22: n_height[7:0]   = b;
                        6'd23: n_height[15:8]  = b;
                        6'd24: n_height[23:16] = b;
                        6'd25: n_height[31:24] = b;
                        6'd28: n_depth[7:0]    = b;
                        6'd29: n_depth[15:8]   = b;
                        default: ;
                    endcase
                    n_pos = n_pos + 32'd1;
                    if (n_pos == 32'(btls_pkg::HEADER_BYTES)) begin
                        n_bad_b = 1'b0;
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                        if (n_depth != 16'd24) n_st = btls_pkg::ST_DEPTH;
                        else if (n_width == 0 || n_width > 32'(MAX_WIDTH) ||
                                 n_height == 0 || n_height > 32'(MAX_HEIGHT))
                            n_st = btls_pkg::ST_SIZE;
                        else if (n_offset < 32'(btls_pkg::HEADER_BYTES))
                            n_st = btls_pkg::ST_OFFSET;
                        else begin
                            n_emit = 1'b0;
                            n_phase = (n_offset == 32'(btls_pkg::HEADER_BYTES))
                                      ? PH_DATA : PH_SKIP;
                            // top store row is height-1
                            n_wbase = (AB+2)'(n_height[HB-1:0] - 1'b1)
                                      * (AB+2)'(n_width[WB-1:0]);
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_pos = n_pos + 32'd1;
                if (n_pos == n_offset) n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (n_chan == 2'd0) begin
                    n_part[7:0] = b; n_chan = 2'd1;
                end else if (n_chan == 2'd1) begin
                    n_part[15:8] = b; n_chan = 2'd2;
                end else begin
                    n_we = 1'b1;
                    n_chan = '0; n_part = '0;
                    n_col = r_col + 1'b1;
                    if (n_col >= w_t) begin
                        if ((32'(r_row) + 32'd1 < r_height) && (w_t[1:0] != 2'd0)) begin
                            n_pad = '0; n_phase = PH_PAD;
                        end else do_next_row = 1'b1;
                    end
                end
            end
            PH_PAD: begin
                n_pad = r_pad + 1'b1;
                if (n_pad >= w_t[1:0]) do_next_row = 1'b1;
            end
            PH_IDLE: ;
            default: ;
        endcase
        if (do_next_row) begin
            n_col = '0;
            n_row = r_row + 1'b1;
            n_wbase = r_wbase - (AB+2)'(w_t);
            if (32'(n_row) >= r_height) begin
                n_phase = PH_IDLE; n_tex_valid = 1'b1; n_emit = 1'b1;
                n_st = btls_pkg::ST_OK;
            end else n_phase = PH_DATA;
        end
    end

    // texel store writes and sample read port
    always_ff @(posedge i_clk) begin
        if (is_file && n_we && !i_req.first_byte)
            r_mem[waddr[AB-1:0]] <= {b, r_part};
        r_rd <= r_mem[r_raddr];
    end

    // sample pipeline datapath: scale, clamp and address
    logic [FB-1:0] fu;
    logic [FB:0]   fv;
    logic [WB-1:0] sx;
    logic [HB-1:0] sy;
    assign fu = i_req.u_coord[FB-1:0];
    assign fv = (FB+1)'(1) << FB;
    always_comb begin
        sx = r_pu[FB+WB-1:FB];
        sy = r_pv[FB+HB-1:FB];
        if (sx > w_t - 1'b1) sx = w_t - 1'b1;
        if (sy > h_t - 1'b1) sy = h_t - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (is_samp) begin
            r_pu <= (FB+WB)'(fu) * (FB+WB)'(w_t - 1'b1);
            r_pv <= (FB+HB)'(fv - (FB+1)'(i_req.v_coord[FB-1:0]))
                    * (FB+HB)'(h_t - 1'b1);
        end
        if (r_ss == SS_MUL) begin
            r_px <= sx;
            r_py <= sy;
        end
        if (r_ss == SS_ADDR)
            r_raddr <= AB'((AB+HB)'(r_py) * (AB+HB)'(w_t) + (AB+HB)'(r_px));
    end

    // control state, parser registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_ss <= SS_IDLE;
            r_pos <= '0; r_offset <= '0; r_width <= '0; r_height <= '0;
            r_depth <= '0; r_part <= '0; r_col <= '0; r_row <= '0;
            r_chan <= '0; r_pad <= '0; r_bad_b <= 1'b0; r_tex_valid <= 1'b0;
            r_wbase <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (is_file) begin
                r_phase <= n_phase; r_pos <= n_pos; r_offset <= n_offset;
                r_width <= n_width; r_height <= n_height; r_depth <= n_depth;
                r_part <= n_part; r_col <= n_col; r_row <= n_row;
                r_chan <= n_chan; r_pad <= n_pad; r_bad_b <= n_bad_b;
                r_tex_valid <= n_tex_valid; r_wbase <= n_wbase;
                if (n_emit) begin
                    r_ovalid <= 1'b1;
                    r_res <= '{1'b0, n_st, 8'd0, 8'd0, 8'd0};
                end
            end
            if (is_samp) begin
                if (!r_tex_valid) begin
                    r_ovalid <= 1'b1;
                    r_res <= '{1'b1, btls_pkg::ST_NO_TEXTURE, 8'd0, 8'd0, 8'd0};
                end else r_ss <= SS_MUL;
            end
            unique case (r_ss)
                SS_MUL:  r_ss <= SS_ADDR;
                SS_ADDR: r_ss <= SS_READ;
                // store data lands in r_rd in the cycle after the address
                SS_READ: r_ss <= SS_DATA;
                SS_DATA: begin
                    r_ss <= SS_IDLE;
                    r_ovalid <= 1'b1;
                    r_res <= '{1'b1, btls_pkg::ST_OK, r_rd[7:0], r_rd[15:8], r_rd[23:16]};
                end
                SS_IDLE: ;
                default: r_ss <= SS_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/bmp_texture_load_and_sample.sv @@
// Top level of the BMP texture loader and nearest-neighbour sampler.
// A file byte is handled as the back end takes it; a sample request goes
// from acceptance to result through the queue hop and the sampler's
// multiply, address, registered store read and output steps,
// during which the back end takes no other request (a sample with no
// texture loaded is answered like a file byte). A two-entry request queue
// sits in front, and one output register holds the result until it is
// taken. The texel store needs no clearing pass after reset.
module bmp_texture_load_and_sample #(
    parameter int MAX_WIDTH    = btls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = btls_pkg::MAX_HEIGHT_DEF,
    parameter int UV_FRAC_BITS = btls_pkg::UV_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_file_byte,
    input  logic        i_first_byte,
    input  logic signed [31:0] i_u_coord,
    input  logic signed [31:0] i_v_coord,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_sample,
    output logic [2:0]  o_status,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_green,
    output logic [7:0]  o_red
);

    btls_pkg::t_req req_in, req_q;
    btls_pkg::t_res res;
    logic q_valid, q_ready;

    assign req_in = '{i_op, i_file_byte, i_first_byte, i_u_coord, i_v_coord};

    btls_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_valid), .o_ready(o_ready), .i_req(req_in),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(req_q)
    );

    btls_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .UV_FRAC_BITS(UV_FRAC_BITS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_req(req_q),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res)
    );

    assign o_is_sample = res.is_sample;
    assign o_status    = res.status;
    assign o_blue      = res.blue;
    assign o_green     = res.green;
    assign o_red       = res.red;

endmodule

@@ rtl/btls_checker.sv @@
// Port-level checks of the texture loader and sampler, bound to the top.
module btls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_is_sample,
    input logic [2:0] o_status,
    input logic [7:0] o_blue,
    input logic [7:0] o_green,
    input logic [7:0] o_red
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= btls_pkg::ST_NO_TEXTURE)
        else $error("status code out of range");

    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_is_sample || o_status != btls_pkg::ST_OK)
        |-> o_blue == 8'd0 && o_green == 8'd0 && o_red == 8'd0)
        else $error("non-zero channels in report");

    a_sample_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_sample
        |-> o_status == btls_pkg::ST_OK || o_status == btls_pkg::ST_NO_TEXTURE)
        else $error("bad status on sample answer");

endmodule

bind bmp_texture_load_and_sample btls_checker u_checker (.*);

@@ sim/tb_bmp_texture_load_and_sample.sv @@
// Testbench for the BMP texture loader and nearest-neighbour sampler.
`timescale 1ns / 1ps

module tb_bmp_texture_load_and_sample;

    localparam int TEX_W_MAX  = 256;
    localparam int TEX_H_MAX  = 256;
    localparam int FRAC_BITS  = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_TARGET = 850;

    // Load phases of the predictor
    typedef enum logic [2:0] {
        LD_IDLE, LD_HEADER, LD_SKIP, LD_DATA, LD_PAD
    } t_load;

    typedef struct {
        bit        op;
        bit [7:0]  fb;
        bit        first;
        bit [31:0] u;
        bit [31:0] v;
        bit        typed;   // expected result given in the row
        bit        has_res;
        btls_pkg::t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_op = 1'b0;
    logic [7:0]  i_file_byte = '0;
    logic        i_first_byte = 1'b0;
    logic signed [31:0] i_u_coord = '0;
    logic signed [31:0] i_v_coord = '0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_is_sample;
    logic [2:0]  o_status;
    logic [7:0]  o_blue, o_green, o_red;

    bmp_texture_load_and_sample DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    t_load       ld_phase = LD_IDLE;
    int unsigned byte_pos, hdr_off, hdr_w, hdr_h, depth, col, row, chan, pad, part;
    bit          tex_loaded = 1'b0;
    logic [23:0] texels [TEX_W_MAX*TEX_H_MAX];

    btls_pkg::t_res pending_results [$];
    int          errors = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          req_taken = 1'b0;

    function automatic btls_pkg::t_res make_res(bit smp, btls_pkg::t_status st,
                                                logic [23:0] bgr);
        btls_pkg::t_res r;
        r.is_sample = smp;
        r.status    = st;
        r.blue      = bgr[7:0];
        r.green     = bgr[15:8];
        r.red       = bgr[23:16];
        return r;
    endfunction

    function automatic int unsigned scale_pos(int unsigned f, int unsigned sz);
        longint unsigned prod;
        int unsigned pos;
        prod = longint'(f) * longint'(sz - 1);
        pos  = int'(prod >> FRAC_BITS);
        if (pos > sz - 1) pos = sz - 1;
        return pos;
    endfunction

    // Row advance after a full row and its padding
    task automatic row_done(output bit got, output btls_pkg::t_res r);
        col = 0;
        row++;
        if (row >= hdr_h) begin
            ld_phase   = LD_IDLE;
            tex_loaded = 1'b1;
            got = 1'b1;
            r   = make_res(1'b0, btls_pkg::ST_OK, '0);
        end else begin
            ld_phase = LD_DATA;
        end
    endtask

    task automatic load_fail(btls_pkg::t_status st, output bit got,
                             output btls_pkg::t_res r);
        ld_phase = LD_IDLE;
        got = 1'b1;
        r   = make_res(1'b0, st, '0);
    endtask

    task automatic header_in(int unsigned b, output bit got, output btls_pkg::t_res r);
        int unsigned p;
        p = byte_pos;
        if (p == 0 && b != btls_pkg::SIG_B) part = 1;
        if (p == 1 && (part != 0 || b != btls_pkg::SIG_M)) begin
            load_fail(btls_pkg::ST_SIGNATURE, got, r);
            return;
        end
        if (p >= 10 && p <= 13) hdr_off  |= b << (8 * (p - 10));
        if (p >= 18 && p <= 21) hdr_w    |= b << (8 * (p - 18));
        if (p >= 22 && p <= 25) hdr_h    |= b << (8 * (p - 22));
        if (p >= 28 && p <= 29) depth    |= b << (8 * (p - 28));
        byte_pos = p + 1;
        if (p + 1 < btls_pkg::HEADER_BYTES) return;
        part = 0;
        if (depth != 24)
            load_fail(btls_pkg::ST_DEPTH, got, r);
        else if (hdr_w == 0 || hdr_w > TEX_W_MAX || hdr_h == 0 || hdr_h > TEX_H_MAX)
            load_fail(btls_pkg::ST_SIZE, got, r);
        else if (hdr_off < btls_pkg::HEADER_BYTES)
            load_fail(btls_pkg::ST_OFFSET, got, r);
        else
            ld_phase = (hdr_off == btls_pkg::HEADER_BYTES) ? LD_DATA : LD_SKIP;
    endtask

    // One accepted request through the predictor
    task automatic predict(t_row it, output bit got, output btls_pkg::t_res r);
        int unsigned b, idx, fu, fv;
        got = 1'b0;
        r   = make_res(1'b0, btls_pkg::ST_OK, '0);
        b   = 32'(it.fb);
        if (it.op) begin
            got = 1'b1;
            if (!tex_loaded) begin
                r = make_res(1'b1, btls_pkg::ST_NO_TEXTURE, '0);
            end else begin
                fu  = it.u & ((1 << FRAC_BITS) - 1);
                fv  = (1 << FRAC_BITS) - (it.v & ((1 << FRAC_BITS) - 1));
                idx = scale_pos(fv, hdr_h) * hdr_w + scale_pos(fu, hdr_w);
                r   = make_res(1'b1, btls_pkg::ST_OK, texels[idx]);
            end
            return;
        end
        if (it.first) begin
            tex_loaded = 1'b0;
            ld_phase   = LD_HEADER;
            byte_pos = 0; hdr_off = 0; hdr_w = 0; hdr_h = 0; depth = 0;
            col = 0; row = 0; chan = 0; pad = 0; part = 0;
        end
        case (ld_phase)
            LD_HEADER: header_in(b, got, r);
            LD_SKIP: begin
                byte_pos++;
                if (byte_pos == hdr_off) ld_phase = LD_DATA;
            end
            LD_DATA: begin
                if (chan < 2) begin
                    part |= b << (8 * chan);
                    chan++;
                end else begin
                    idx = (hdr_h - 1 - row) * hdr_w + col;
                    texels[idx] = {b[7:0], part[15:0]};
                    chan = 0;
                    part = 0;
                    col++;
                    if (col >= hdr_w) begin
                        if (row + 1 < hdr_h && (hdr_w & 3) != 0) begin
                            pad = 0;
                            ld_phase = LD_PAD;
                        end else begin
                            row_done(got, r);
                        end
                    end
                end
            end
            LD_PAD: begin
                pad++;
                if (pad >= (hdr_w & 3)) row_done(got, r);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(99);
        if (k < 45) return 0;
        if (k < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Drive one request and wait for it to be taken
    task automatic send(t_row it);
        int gap;
        bit got;
        btls_pkg::t_res r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= it.op;
        i_file_byte  <= it.fb;
        i_first_byte <= it.first;
        i_u_coord    <= it.u;
        i_v_coord    <= it.v;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        predict(it, got, r);
        if (it.typed) begin
            got = it.has_res;
            r   = it.res;
        end
        if (got) pending_results.push_back(r);
    endtask

    function automatic t_row byte_row(bit [7:0] b, bit first);
        t_row it;
        it = '{default: '0};
        it.fb    = b;
        it.first = first;
        it.u     = $urandom();
        it.v     = $urandom();
        return it;
    endfunction

    function automatic t_row sample_row(bit [31:0] u, bit [31:0] v);
        t_row it;
        it = '{default: '0};
        it.op    = 1'b1;
        it.u     = u;
        it.v     = v;
        it.fb    = 8'($urandom());
        it.first = 1'($urandom());
        return it;
    endfunction

    function automatic bit [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {16'($urandom_range(3) - 2), 16'h0000};
            3: return {16'h0000, 16'hFFFF};
            default: return $urandom();
        endcase
    endfunction

    // Stream a whole file; trunc > 0 stops after that many bytes
    task automatic send_bmp(int unsigned w, int unsigned h, int unsigned off,
                            int unsigned dep, bit sig_ok, int trunc, bit samples_inside);
        bit [7:0] f [$];
        int unsigned padn;
        for (int p = 0; p < btls_pkg::HEADER_BYTES; p++) f.push_back(8'($urandom()));
        f[0] = sig_ok ? btls_pkg::SIG_B : 8'h58;
        f[1] = btls_pkg::SIG_M;
        for (int k = 0; k < 4; k++) begin
            f[10 + k] = 8'(off >> (8 * k));
            f[18 + k] = 8'(w >> (8 * k));
            f[22 + k] = 8'(h >> (8 * k));
        end
        f[28] = dep[7:0];
        f[29] = dep[15:8];
        for (int unsigned p = btls_pkg::HEADER_BYTES; p < off; p++)
            f.push_back(8'($urandom()));
        if (w <= TEX_W_MAX && h <= TEX_H_MAX) begin
            padn = (4 - ((w * 3) & 3)) & 3;
            for (int unsigned y = 0; y < h; y++) begin
                for (int unsigned x = 0; x < 3 * w + padn; x++)
                    f.push_back(8'($urandom()));
            end
        end
        for (int k = $urandom_range(2); k > 0; k--) f.push_back(8'($urandom()));
        foreach (f[i]) begin
            if (trunc > 0 && i >= trunc) break;
            if (samples_inside && $urandom_range(30) == 0)
                send(sample_row(pick_coord(), pick_coord()));
            send(byte_row(f[i], i == 0));
        end
    endtask

    task automatic send_samples(int n);
        for (int k = 0; k < n; k++) send(sample_row(pick_coord(), pick_coord()));
    endtask

    // Result checker
    always @(posedge i_clk) begin
        btls_pkg::t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result is_sample=%0d status=%0d bgr=%h%h%h",
                         $time, o_is_sample, o_status, o_blue, o_green, o_red);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_is_sample !== want.is_sample) begin
                    $display("%0t: is_sample expected %0d actual %0d",
                             $time, want.is_sample, o_is_sample);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_blue !== want.blue || o_green !== want.green || o_red !== want.red) begin
                    $display("%0t: bgr expected %h %h %h actual %h %h %h", $time,
                             want.blue, want.green, want.red, o_blue, o_green, o_red);
                    errors++;
                end
            end
        end
    end

    // Output-side back-pressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
            stall_left <= pick_gap();
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no request and no result taken
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** bmp_texture_load_and_sample: FAILED **");
                $finish;
            end
        end
    end

    t_row directed [$];

    initial begin
        t_row it;
        // Directed rows: sampling with no texture, stray bytes, bad signatures
        it = sample_row(32'h7FFF_FFFF, 32'h8000_0000);
        it.typed = 1'b1; it.has_res = 1'b1;
        it.res = make_res(1'b1, btls_pkg::ST_NO_TEXTURE, '0);
        directed.push_back(it);
        directed.push_back(byte_row(8'hFF, 1'b0));
        directed.push_back(byte_row(8'h58, 1'b1));
        it = byte_row(btls_pkg::SIG_M, 1'b0);
        it.typed = 1'b1; it.has_res = 1'b1;
        it.res = make_res(1'b0, btls_pkg::ST_SIGNATURE, '0);
        directed.push_back(it);
        directed.push_back(byte_row(8'h00, 1'b0));
        directed.push_back(byte_row(btls_pkg::SIG_B, 1'b1));
        it = byte_row(8'h51, 1'b0);
        it.typed = 1'b1; it.has_res = 1'b1;
        it.res = make_res(1'b0, btls_pkg::ST_SIGNATURE, '0);
        directed.push_back(it);
        it = sample_row(32'h0, 32'h0);
        it.typed = 1'b1; it.has_res = 1'b1;
        it.res = make_res(1'b1, btls_pkg::ST_NO_TEXTURE, '0);
        directed.push_back(it);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send(directed[i]);

        // Header errors and small textures at the extremes
        send_bmp(2, 2, 54, 32, 1, 0, 0);
        send_bmp(0, 2, 54, 24, 1, 0, 0);
        send_bmp(257, 1, 54, 24, 1, 0, 0);
        send_bmp(1, 32'hFFFF_FFFF, 54, 24, 1, 0, 0);
        send_bmp(1, 1, 53, 24, 1, 0, 0);
        send_bmp(1, 1, 54, 24, 1, 0, 0);
        send_samples(4);
        send_bmp(2, 2, 60, 24, 1, 0, 0);
        send_samples(4);
        send_bmp(3, 2, 54, 24, 1, 30, 1);
        send_samples(2);
        // largest sizes pass the header check; the load is cut short
        send_bmp(256, 1, 54, 24, 1, 80, 0);
        send_samples(3);
        send_bmp(1, 256, 54, 24, 1, 80, 0);
        send_samples(3);

        // Random files, mostly well formed, each followed by samples
        while (items_sent < ITEM_TARGET) begin
            int unsigned w, h, off, dep;
            int k;
            w   = $urandom_range(5, 1);
            h   = $urandom_range(5, 1);
            off = ($urandom_range(3) == 0) ? $urandom_range(70, 55) : 54;
            dep = 24;
            k   = $urandom_range(99);
            if (k < 3) begin
                w = $urandom_range(40, 20);
                h = 1;
            end else if (k < 6) begin
                dep = $urandom_range(1) ? $urandom() : 8;
            end else if (k < 9) begin
                if ($urandom_range(1)) w = $urandom_range(1) ? 0 : $urandom_range(4000, 257);
                else h = $urandom_range(1) ? 0 : $urandom();
            end else if (k < 12) begin
                off = $urandom_range(53);
            end
            send_bmp(w, h, off, dep, $urandom_range(19) != 0,
                     ($urandom_range(9) == 0) ? $urandom_range(80, 1) : 0,
                     1'($urandom_range(1)));
            if ($urandom_range(3) == 0) send(byte_row(8'($urandom()), 1'b0));
            send_samples($urandom_range(8, 1));
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("** bmp_texture_load_and_sample: PASSED **");
        else
            $display("** bmp_texture_load_and_sample: FAILED **");
        $finish;
    end

endmodule

@@ bmp_texture_load_and_sample.f @@
rtl/btls_pkg.sv
rtl/btls_front.sv
rtl/btls_back.sv
rtl/bmp_texture_load_and_sample.sv
rtl/btls_checker.sv
sim/tb_bmp_texture_load_and_sample.sv
